[rtl/prsw_pkg.sv]
`default_nettype none

package prsw_pkg;

    localparam int unsigned ROM_DEPTH = 16;

    // Setup words sent before the frequency word; unused slots read as zero.
    localparam logic [31:0] SETUP_ROM [ROM_DEPTH] = '{
        32'h0000_0017, 32'h0000_008D, 32'h0000_001C, 32'h2800_1409,
        32'h0111_CE58, 32'h001F_3326, 32'hA000_0005, 32'h8804_3284,
        32'h0D80_6003, 32'h0400_0642, 32'h0005_1401, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
    };

    // Request kinds carried on s_tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_FREQ_BASE   = 2'd1,
        CFG_CHAN_STEP   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    localparam logic [9:0]  HALF_PERIOD_RESET = 10'd100;
    localparam logic [31:0] FREQ_BASE_RESET   = 32'h0000_6430;
    localparam logic [7:0]  CHAN_STEP_RESET   = 8'd6;

endpackage

`default_nettype wire

[rtl/pll_register_sequence_writer.sv]
`default_nettype none

// Channel   | Direction | Payload
// ----------+-----------+-----------------------------------------------------
// s_*       | in        | tuser = mode (start / tick), tdata = channel
// m_*       | out       | tdata = clock, data, latch, busy, start rejected
// cfg_*     | in        | cfg_index selects register, cfg_data; always ready
//
// Every request updates the sequencer state and its pin levels land in the
// output register on the same edge, so a new request is taken every cycle
// while the output side keeps up.
// A stalled result holds in the output register and drops s_tready; a result
// taken by m_tready frees the slot on that edge, so no bubble appears.
// Reset clears the sequencer to idle with all pins low and loads the defaults.
module pll_register_sequence_writer
    import prsw_pkg::*;
#(
    parameter int unsigned SETUP_WORDS = 11,
    parameter int unsigned WORD_BITS   = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] channel
    input  wire logic        s_tuser,   // [0] mode: start or tick

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] serial_clock, [1] serial_data, [2] latch_enable, [3] busy_res,
    // [4] start_rejected, [7:5] zero
    output logic [7:0]       m_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_DATA  = 3'd2,
        PH_CLKHI = 3'd3,
        PH_POST  = 3'd4,
        PH_LEHI  = 3'd5,
        PH_LELO  = 3'd6
    } phase_t;

    localparam logic [3:0] LAST_SETUP = 4'(SETUP_WORDS);
    localparam logic [5:0] BIT_COUNT  = 6'(WORD_BITS);

    // Configuration
    logic [9:0]  half_period_reg;
    logic [31:0] freq_base_reg;
    logic [7:0]  chan_step_reg;

    // Sequencer state
    phase_t                 phase_reg,      phase_next;
    logic [3:0]             word_idx_reg,   word_idx_next;
    logic [5:0]             bit_idx_reg,    bit_idx_next;
    logic [WORD_BITS-1:0]   shift_reg,      shift_next;
    logic [9:0]             wait_cnt_reg,   wait_cnt_next;
    logic [31:0]            final_word_reg, final_word_next;
    logic                   clk_pin_reg,    clk_pin_next;
    logic                   data_pin_reg,   data_pin_next;
    logic                   le_pin_reg,     le_pin_next;

    // Output register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    logic        accept;
    logic        busy;
    logic        rejected;
    logic [9:0]  half_eff;
    logic [9:0]  wait_inc;
    logic [15:0] chan_prod;
    logic [3:0]  word_idx_inc;
    logic [5:0]  bit_idx_inc;
    logic [31:0] next_word;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign busy         = (phase_reg != PH_IDLE);
    assign rejected     = (s_tuser == MODE_START) && busy;
    assign half_eff     = (half_period_reg == 10'd0) ? 10'd1 : half_period_reg;
    assign wait_inc     = wait_cnt_reg + 10'd1;
    assign chan_prod    = 16'(s_tdata) * 16'(chan_step_reg);
    assign word_idx_inc = word_idx_reg + 4'd1;
    assign bit_idx_inc  = bit_idx_reg + 6'd1;
    // Word that follows the current one: ROM slot or the frequency word
    assign next_word    = (word_idx_inc < LAST_SETUP) ? SETUP_ROM[word_idx_inc]
                                                      : final_word_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        word_idx_next   = word_idx_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        wait_cnt_next   = wait_cnt_reg;
        final_word_next = final_word_reg;
        clk_pin_next    = clk_pin_reg;
        data_pin_next   = data_pin_reg;
        le_pin_next     = le_pin_reg;

        if (s_tuser == MODE_START)
        begin
            if (!busy)
            begin
                // Latch the frequency word and start with the first ROM word
                final_word_next = freq_base_reg + {12'd0, chan_prod, 4'd0};
                word_idx_next   = 4'd0;
                bit_idx_next    = 6'd0;
                shift_next      = (LAST_SETUP != 4'd0) ? SETUP_ROM[0][WORD_BITS-1:0]
                                                       : final_word_next[WORD_BITS-1:0];
                wait_cnt_next   = 10'd0;
                clk_pin_next    = 1'b0;
                le_pin_next     = 1'b0;
                phase_next      = PH_PRE;
            end
        end
        else if (busy)
        begin
            wait_cnt_next = wait_inc;
            if (wait_inc >= half_eff)
            begin
                wait_cnt_next = 10'd0;
                case (phase_reg)
                    PH_PRE:
                    begin
                        data_pin_next = shift_reg[WORD_BITS-1];
                        phase_next    = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        clk_pin_next = 1'b1;
                        phase_next   = PH_CLKHI;
                    end
                    PH_CLKHI:
                    begin
                        // Falling clock edge: advance to the next bit
                        clk_pin_next = 1'b0;
                        shift_next   = shift_reg << 1;
                        bit_idx_next = bit_idx_inc;
                        if (bit_idx_inc < BIT_COUNT)
                        begin
                            data_pin_next = shift_reg[WORD_BITS-2];
                            phase_next    = PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_POST;
                        end
                    end
                    PH_POST:
                    begin
                        le_pin_next = 1'b1;
                        phase_next  = PH_LEHI;
                    end
                    PH_LEHI:
                    begin
                        le_pin_next = 1'b0;
                        phase_next  = PH_LELO;
                    end
                    PH_LELO:
                    begin
                        if (word_idx_reg >= LAST_SETUP)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            word_idx_next = word_idx_inc;
                            bit_idx_next  = 6'd0;
                            shift_next    = next_word[WORD_BITS-1:0];
                            clk_pin_next  = 1'b0;
                            le_pin_next   = 1'b0;
                            phase_next    = PH_PRE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            freq_base_reg   <= FREQ_BASE_RESET;
            chan_step_reg   <= CHAN_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg <= cfg_data[9:0];
                CFG_FREQ_BASE:   freq_base_reg   <= cfg_data;
                CFG_CHAN_STEP:   chan_step_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            word_idx_reg   <= 4'd0;
            bit_idx_reg    <= 6'd0;
            shift_reg      <= '0;
            wait_cnt_reg   <= 10'd0;
            final_word_reg <= 32'd0;
            clk_pin_reg    <= 1'b0;
            data_pin_reg   <= 1'b0;
            le_pin_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= 8'd0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                word_idx_reg   <= word_idx_next;
                bit_idx_reg    <= bit_idx_next;
                shift_reg      <= shift_next;
                wait_cnt_reg   <= wait_cnt_next;
                final_word_reg <= final_word_next;
                clk_pin_reg    <= clk_pin_next;
                data_pin_reg   <= data_pin_next;
                le_pin_reg     <= le_pin_next;
                m_valid_reg    <= 1'b1;
                m_data_reg     <= {3'd0, rejected, (phase_next != PH_IDLE),
                                   le_pin_next, data_pin_next, clk_pin_next};
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Clock and latch are never high together on the pins
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[2]))
        else $error("clock and latch enable high together");

    // Idle sequencer leaves clock and latch low
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (!clk_pin_reg && !le_pin_reg))
        else $error("pin left high while idle");

    // Bit counter never runs past the word length
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= BIT_COUNT)
        else $error("bit index past word length");

    // A start taken while idle always leaves the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == MODE_START) && !busy) |=> (phase_reg == PH_PRE))
        else $error("start did not launch sequence");

endmodule

`default_nettype wire

[test/pll_sequence_checker.sv]
// Watches the request, result and register channels of the sequence writer,
// keeps its own copy of the sequencer and compares every result it sees.
module pll_sequence_checker
    import prsw_pkg::*;
#(
    parameter int unsigned SETUP_WORDS = 11,
    parameter int unsigned WORD_BITS   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,

    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,

    output int unsigned       mismatches,
    output int unsigned       pins_pending,
    output logic              seq_busy
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_DATA,
        PH_CLK_HIGH,
        PH_POST,
        PH_LATCH_HIGH,
        PH_LATCH_LOW
    } seq_phase_t;

    // Same bit order as m_tdata, serial clock in bit 0.
    typedef struct packed {
        logic [2:0] pad;
        logic       rejected;
        logic       busy;
        logic       latch;
        logic       data;
        logic       clock;
    } pin_result_t;

    logic [9:0]  half_period;
    logic [31:0] freq_base;
    logic [7:0]  chan_step;

    seq_phase_t  phase;
    logic [3:0]  word_idx;
    logic [5:0]  bit_idx;
    logic [31:0] shift_reg;
    logic [9:0]  wait_ticks;
    logic [31:0] freq_word;
    logic        pin_clk;
    logic        pin_data;
    logic        pin_le;

    pin_result_t expected_pins[$];
    int unsigned results_seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result %0d: got %0h, want %0h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    function automatic void load_word();
        logic [31:0] w;
        if (word_idx < SETUP_WORDS)
            w = SETUP_ROM[word_idx];
        else
            w = freq_word;
        shift_reg = w << (32 - WORD_BITS);
        bit_idx   = '0;
    endfunction

    function automatic void end_of_wait();
        case (phase)
            PH_PRE:
            begin
                pin_data = shift_reg[31];
                phase    = PH_DATA;
            end
            PH_DATA:
            begin
                pin_clk = 1'b1;
                phase   = PH_CLK_HIGH;
            end
            PH_CLK_HIGH:
            begin
                pin_clk   = 1'b0;
                shift_reg = shift_reg << 1;
                bit_idx   = bit_idx + 6'd1;
                if (bit_idx < WORD_BITS)
                begin
                    pin_data = shift_reg[31];
                    phase    = PH_DATA;
                end
                else
                begin
                    phase = PH_POST;
                end
            end
            PH_POST:
            begin
                pin_le = 1'b1;
                phase  = PH_LATCH_HIGH;
            end
            PH_LATCH_HIGH:
            begin
                pin_le = 1'b0;
                phase  = PH_LATCH_LOW;
            end
            PH_LATCH_LOW:
            begin
                if (word_idx >= SETUP_WORDS)
                begin
                    phase = PH_IDLE;
                end
                else
                begin
                    word_idx = word_idx + 4'd1;
                    load_word();
                    pin_clk = 1'b0;
                    pin_le  = 1'b0;
                    phase   = PH_PRE;
                end
            end
            default:
                phase = PH_IDLE;
        endcase
    endfunction

    // Advance the sequencer by one request and return the pin levels after it.
    function automatic pin_result_t next_pin_levels(input logic mode,
                                                    input logic [7:0] chan);
        pin_result_t r;
        logic        rejected;
        logic [9:0]  hp;
        rejected = 1'b0;
        if (mode == MODE_START)
        begin
            if (phase != PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                freq_word  = freq_base + ((32'(chan) * 32'(chan_step)) << 4);
                word_idx   = '0;
                load_word();
                wait_ticks = '0;
                pin_clk    = 1'b0;
                pin_le     = 1'b0;
                phase      = PH_PRE;
            end
        end
        else if (phase != PH_IDLE)
        begin
            hp         = (half_period == '0) ? 10'd1 : half_period;
            wait_ticks = wait_ticks + 10'd1;
            if (wait_ticks >= hp)
            begin
                wait_ticks = '0;
                end_of_wait();
            end
        end
        r.pad      = '0;
        r.rejected = rejected;
        r.busy     = (phase != PH_IDLE);
        r.latch    = pin_le;
        r.data     = pin_data;
        r.clock    = pin_clk;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pin_result_t got;
        pin_result_t want;
        if (!rst_n)
        begin
            half_period  = HALF_PERIOD_RESET;
            freq_base    = FREQ_BASE_RESET;
            chan_step    = CHAN_STEP_RESET;
            phase        = PH_IDLE;
            word_idx     = '0;
            bit_idx      = '0;
            shift_reg    = '0;
            wait_ticks   = '0;
            freq_word    = '0;
            pin_clk      = 1'b0;
            pin_data     = 1'b0;
            pin_le       = 1'b0;
            results_seen = 0;
            mismatches   = 0;
            expected_pins.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_HALF_PERIOD: half_period = cfg_data[9:0];
                    CFG_FREQ_BASE:   freq_base   = cfg_data;
                    CFG_CHAN_STEP:   chan_step   = cfg_data[7:0];
                    default: ;
                endcase
            end
            // Retire the result before queueing this edge's request.
            if (m_tvalid && m_tready)
            begin
                got = pin_result_t'(m_tdata);
                if (expected_pins.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(m_tdata), '0);
                end
                else
                begin
                    want = expected_pins.pop_front();
                    if (got.clock !== want.clock)
                        report_mismatch("serial_clock", 32'(got.clock),
                                        32'(want.clock));
                    if (got.data !== want.data)
                        report_mismatch("serial_data", 32'(got.data),
                                        32'(want.data));
                    if (got.latch !== want.latch)
                        report_mismatch("latch_enable", 32'(got.latch),
                                        32'(want.latch));
                    if (got.busy !== want.busy)
                        report_mismatch("busy", 32'(got.busy), 32'(want.busy));
                    if (got.rejected !== want.rejected)
                        report_mismatch("start_rejected", 32'(got.rejected),
                                        32'(want.rejected));
                    if (got.pad !== want.pad)
                        report_mismatch("padding", 32'(got.pad), 32'(want.pad));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                expected_pins.push_back(next_pin_levels(s_tuser, s_tdata));
        end
        pins_pending = expected_pins.size();
        seq_busy     = (phase != PH_IDLE);
    end

endmodule

[test/pll_register_sequence_writer_test.sv]
// Top of the sequence writer regression: drives requests and register
// writes, paces the result side and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module pll_register_sequence_writer_test;
    import prsw_pkg::*;

    // Slowest correct run: about a thousand requests, each behind the longest
    // send gap and the longest result stall, plus the long hold and the
    // register writes. Take several times that.
    localparam int unsigned LIMIT_CYCLES      = 200_000;
    localparam int unsigned LONG_HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES     = 8;
    localparam int unsigned QUIET_LEAD_CYCLES = 18;
    localparam int unsigned TAIL_TICKS        = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] channel
    logic        s_tuser   = 1'b0; // [0] mode: start or tick

    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    // [0] serial_clock, [1] serial_data, [2] latch_enable, [3] busy,
    // [4] start_rejected, [7:5] zero
    wire  [7:0]  m_tdata;

    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int unsigned mismatches;
    int unsigned pins_pending;
    logic        seq_busy;

    // Handshake between the stimulus and the result pacing process.
    bit          quiet     = 1'b0;  // no idling on either side
    bit          long_hold = 1'b0;  // ask the receiver for one long hold-off

    int unsigned cycles    = 0;

    pll_register_sequence_writer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pll_sequence_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pins_pending (pins_pending),
        .seq_busy     (seq_busy)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog: end the run if the limit passes before the verdict.
    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side pacing. Stall in random bursts, hold off once for a long
    // stretch on request so the block fills up and drops s_tready, and keep
    // ready high throughout the quiet tail.
    initial
    begin
        int unsigned stall;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until it is taken. Called at a falling
    // edge and returns at a falling edge with tvalid still high, so that
    // back-to-back requests stream without a bubble.
    task automatic send_request(input logic mode, input logic [7:0] chan);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= chan;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_request(MODE_TICK, 8'($urandom));
    endtask

    // Drop the request stream and wait until every result is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pins_pending != 0);
    endtask

    // Write one register; only called with the request stream drained.
    task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Start a sequence and tick it through to the end. Now and then a start
    // is thrown in while busy; those must come back rejected.
    task automatic run_sequence(input logic [7:0] chan);
        send_request(MODE_START, chan);
        while (seq_busy)
        begin
            if (!quiet && $urandom_range(0, 39) == 0)
                send_request(MODE_START, 8'($urandom));
            else
                send_request(MODE_TICK, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Ticks while idle change nothing.
        send_request(MODE_TICK, 8'hFF);
        send_request(MODE_TICK, 8'h00);
        drain();

        // Extremes: frequency word wraps past 2^32 with the largest base, step
        // and channel; the unused index must leave everything alone.
        write_register(CFG_FREQ_BASE, 32'hFFFF_FFFF);
        write_register(CFG_CHAN_STEP, 32'h0000_00FF);
        write_register(CFG_UNUSED, 32'h5A5A_A5A5);

        // Start with the top channel under the reset half period, then starts
        // while busy.
        send_request(MODE_START, 8'hFF);
        send_request(MODE_START, 8'h00);
        send_request(MODE_START, 8'hAA);
        send_ticks(18);
        drain();

        // Shorten the wait, get past the first wait so the data pin takes the
        // first bit, then drop to zero in the middle of a wait: zero counts as
        // one and the wait ends at once. Finish the sequence under the long
        // hold-off; the start that opens it comes back rejected.
        write_register(CFG_HALF_PERIOD, 32'd40);
        send_ticks(30);
        drain();
        write_register(CFG_HALF_PERIOD, 32'd0);
        long_hold = 1'b1;
        run_sequence(8'h00);
        drain();

        // Quiet tail: full rate on both sides.
        quiet = 1'b1;
        repeat (QUIET_LEAD_CYCLES) @(negedge clk);
        write_register(CFG_FREQ_BASE, $urandom);
        write_register(CFG_CHAN_STEP, $urandom_range(0, 255));
        write_register(CFG_HALF_PERIOD, 32'd1);
        send_request(MODE_START, 8'($urandom));
        send_ticks(TAIL_TICKS);
        drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
